[design/geodetic_to_cartesian_assert.svh]
// assertion macros for the geodetic to cartesian block
// used by design/geodetic_to_cartesian.sv, no other dependencies
`ifndef GEODETIC_TO_CARTESIAN_ASSERT_SVH
`define GEODETIC_TO_CARTESIAN_ASSERT_SVH
`ifndef SYNTH
`define G2C_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("g2c assertion failed");
`define G2C_ASSERT_ANY(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("g2c assertion failed");
`else
`define G2C_ASSERT(lbl, clk, rst, prop)
`define G2C_ASSERT_ANY(lbl, clk, prop)
`endif
`endif

[design/g2c_pkg.sv]
// types, constants and elaboration-time tables for the geodetic to cartesian block
// no dependencies
`timescale 1ns / 1ps
package g2c_pkg;

   localparam int CORDIC_STAGES = 32;
   localparam int STAGE_W       = $clog2(CORDIC_STAGES);
   localparam int NEWTON_STEPS  = 8;
   localparam int MUL_LAT       = 4;
   localparam int NEWTON_LAT    = 3 * MUL_LAT + 1;

   // pipeline timing, counted in edges after the word is accepted
   localparam int T_SC  = CORDIC_STAGES + 2;
   localparam int T_W   = T_SC + 2 * MUL_LAT + 1;
   localparam int T_N   = T_W + NEWTON_STEPS * NEWTON_LAT + MUL_LAT;
   localparam int T_OUT = T_N + 2 + 2 * MUL_LAT;
   localparam int H_DEPTH  = T_N + MUL_LAT;
   localparam int SC_DEPTH = T_N + MUL_LAT - T_SC + 1;

   localparam logic signed [63:0] Q60_ONE   = 64'sd1 <<< 60;
   localparam logic signed [63:0] Q60_TWO   = 64'sd2 <<< 60;
   localparam logic signed [63:0] Q60_THREE = 64'sd3 <<< 60;
   localparam logic signed [63:0] NEWTON_Y0 = 64'sd3 <<< 59;
   localparam logic signed [38:0] OUT_LIMIT = 39'sd200000000000;

   localparam logic [33:0] SEMI_RESET = 34'd6378137000;
   localparam logic [38:0] FLAT_RESET = 39'd3686454311;

   typedef enum logic [0:0] {
      REG_SEMI_MAJOR = 1'b0,
      REG_FLATTENING = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic               neg;
   } cordic_type;

   typedef struct packed {
      logic signed [63:0] slat;
      logic signed [63:0] clat;
      logic signed [63:0] slon;
      logic signed [63:0] clon;
   } trig_type;

   typedef logic signed [63:0] atan_tbl_type [CORDIC_STAGES];

   // shift-and-subtract quotient, only evaluated while building the constant tables
   function automatic logic [63:0] udiv_f(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/m) in q62 by its alternating series
   function automatic logic [63:0] atan_recip_q62(input logic [63:0] m);
      logic [63:0] pw;
      logic [63:0] sum;
      logic [63:0] k;
      logic [63:0] t;
      pw  = udiv_f(64'd1 << 62, m);
      sum = '0;
      k   = '0;
      while (pw != 64'd0) begin
         t = udiv_f(pw, 64'(2 * k + 1));
         if (k[0]) sum = sum - t;
         else sum = sum + t;
         pw = udiv_f(pw, m);
         pw = udiv_f(pw, m);
         k  = k + 64'd1;
      end
      return sum;
   endfunction

   function automatic logic signed [63:0] mul_shift_f(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input int s);
      logic         neg;
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] p;
      logic [127:0] q;
      neg = a[63] ^ b[63];
      ma  = a[63] ? 64'(-a) : 64'(a);
      mb  = b[63] ? 64'(-b) : 64'(b);
      p   = {64'd0, ma} * {64'd0, mb};
      q   = p >> s;
      return neg ? $signed(64'(64'd0 - q[63:0])) : $signed(q[63:0]);
   endfunction

   function automatic logic signed [63:0] inv_sqrt_f(input logic signed [63:0] w);
      logic signed [63:0] y;
      logic signed [63:0] t;
      y = NEWTON_Y0;
      for (int n = 0; n < NEWTON_STEPS; n++) begin
         t = mul_shift_f(w, mul_shift_f(y, y, 60), 60);
         y = mul_shift_f(y, Q60_THREE - t, 61);
      end
      return y;
   endfunction

   function automatic logic signed [63:0] calc_pi();
      return $signed(64'(4 * atan_recip_q62(64'd5) - atan_recip_q62(64'd239)));
   endfunction

   function automatic atan_tbl_type calc_atan();
      atan_tbl_type tbl;
      tbl[0] = calc_pi() >>> 2;
      for (int i = 1; i < CORDIC_STAGES; i++)
         tbl[i] = $signed(atan_recip_q62(64'd1 << i) >> 2);
      return tbl;
   endfunction

   function automatic logic signed [63:0] calc_gain_inv();
      logic signed [63:0] prod;
      prod = Q60_ONE;
      for (int i = 0; i < CORDIC_STAGES; i++)
         if (2 * i < 62) prod = prod + (prod >>> (2 * i));
      return inv_sqrt_f(prod >>> 2) >>> 1;
   endfunction

   localparam logic signed [63:0] PI_Q60       = calc_pi();
   localparam logic signed [63:0] HALF_PI_Q60  = PI_Q60 >>> 1;
   localparam atan_tbl_type       ATAN_TBL     = calc_atan();
   localparam logic signed [63:0] GAIN_INV_Q60 = calc_gain_inv();

endpackage

[design/g2c_mul.sv]
// pipelined exact 64x64 signed product, shifted right and truncated toward zero
// no dependencies
`timescale 1ns / 1ps
module g2c_mul (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   input  logic [6:0]         shift_amt,
   output logic signed [63:0] p
);
   logic         neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]  ma_ff, mb_ff;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] sum_ff;
   logic [127:0] shifted;
   logic [63:0]  p_ff;

   assign shifted = sum_ff >> shift_amt;

   always_ff @(posedge clock) begin
      if (enable) begin
         neg1_ff <= a[63] ^ b[63];
         ma_ff   <= a[63] ? 64'(-a) : 64'(a);
         mb_ff   <= b[63] ? 64'(-b) : 64'(b);
         // four 32x32 partial products
         neg2_ff <= neg1_ff;
         p00_ff  <= 64'(ma_ff[31:0])  * 64'(mb_ff[31:0]);
         p01_ff  <= 64'(ma_ff[31:0])  * 64'(mb_ff[63:32]);
         p10_ff  <= 64'(ma_ff[63:32]) * 64'(mb_ff[31:0]);
         p11_ff  <= 64'(ma_ff[63:32]) * 64'(mb_ff[63:32]);
         neg3_ff <= neg2_ff;
         sum_ff  <= {64'd0, p00_ff} + ({64'd0, p01_ff} << 32)
                  + ({64'd0, p10_ff} << 32) + {p11_ff, 64'd0};
         p_ff    <= neg3_ff ? 64'(64'd0 - shifted[63:0]) : shifted[63:0];
      end
   end

   assign p = $signed(p_ff);
endmodule

[design/g2c_cordic_cell.sv]
// one rotation-mode cordic stage: add/subtract of shifted x, y and the atan constant
// depends on g2c_pkg
`timescale 1ns / 1ps
module g2c_cordic_cell (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [g2c_pkg::STAGE_W-1:0] stage_idx,
   input  g2c_pkg::cordic_type         d_in,
   output g2c_pkg::cordic_type         d_out
);
   g2c_pkg::cordic_type d_ff, d_in_next;
   logic signed [63:0]  dx, dy, ang;

   always_comb begin
      dx  = d_in.y >>> stage_idx;
      dy  = d_in.x >>> stage_idx;
      ang = g2c_pkg::ATAN_TBL[stage_idx];
      d_in_next.neg = d_in.neg;
      if (!d_in.z[63]) begin
         d_in_next.x = d_in.x - dx;
         d_in_next.y = d_in.y + dy;
         d_in_next.z = d_in.z - ang;
      end else begin
         d_in_next.x = d_in.x + dx;
         d_in_next.y = d_in.y - dy;
         d_in_next.z = d_in.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) d_ff <= d_in_next;
   end

   assign d_out = d_ff;
endmodule

[design/g2c_newton_cell.sv]
// one newton step of the inverse square root: y' = y (3 - w y^2) / 2
// depends on g2c_pkg, g2c_mul; squares y, multiplies by w, registers 3 - w y^2, then multiplies by y
`timescale 1ns / 1ps
module g2c_newton_cell (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [63:0] w_in,
   input  logic signed [63:0] y_in,
   output logic signed [63:0] w_out,
   output logic signed [63:0] y_out
);
   localparam int WD = g2c_pkg::NEWTON_LAT;
   localparam int YD = 2 * g2c_pkg::MUL_LAT + 1;

   logic signed [63:0] w_dly_ff [WD];
   logic signed [63:0] y_dly_ff [YD];
   logic signed [63:0] ysq, wysq, c_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         w_dly_ff[0] <= w_in;
         y_dly_ff[0] <= y_in;
         for (int k = 1; k < WD; k++) w_dly_ff[k] <= w_dly_ff[k-1];
         for (int k = 1; k < YD; k++) y_dly_ff[k] <= y_dly_ff[k-1];
         c_ff <= g2c_pkg::Q60_THREE - wysq;
      end
   end

   g2c_mul u_sq (.clock(clock), .enable(enable), .a(y_in), .b(y_in),
                 .shift_amt(7'd60), .p(ysq));
   g2c_mul u_w (.clock(clock), .enable(enable), .a(w_dly_ff[g2c_pkg::MUL_LAT-1]),
                .b(ysq), .shift_amt(7'd60), .p(wysq));
   g2c_mul u_y (.clock(clock), .enable(enable), .a(y_dly_ff[YD-1]), .b(c_ff),
                .shift_amt(7'd61), .p(y_out));

   assign w_out = w_dly_ff[WD-1];
endmodule

[design/geodetic_to_cartesian.sv]
// geodetic to earth-centred cartesian conversion, top level
// depends on g2c_pkg, g2c_mul, g2c_cordic_cell, g2c_newton_cell and the assert header
//
// usage:
//   req_ carries one word (latitude, longitude, height); it is taken on an edge
//   with req_valid high and req_stall low. rsp_ returns one word (x, y, z in mm,
//   saturated to +/-2e11) per request, in order, taken when rsp_valid is high and
//   rsp_stall low. csr_ writes the semi-major axis (index 0) and the flattening
//   (index 1); csr_ready is high out of reset. write them only while no word is in flight.
// path: the two cordic rows side by side, then eight newton cells of the inverse
//   square root and the pipelined multipliers in series.
// throughput: one word per cycle unless the stall below holds the pipeline; every stage is a registered cell.
// stall: while rsp_valid is high and rsp_stall is high the pipeline (all but the ellipsoid terms) holds and
//   req_stall is raised; the held result stays on rsp_ unchanged.
// reset: clears all valid bits and loads the wgs84 ellipsoid into the registers;
//   req_stall is high and csr_ready low while reset is held.
`timescale 1ns / 1ps
`include "geodetic_to_cartesian_assert.svh"
module geodetic_to_cartesian (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_lat_angle,
   input  logic signed [31:0] req_lon_angle,
   input  logic signed [37:0] req_height_mm,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [38:0] rsp_x_mm,
   output logic signed [38:0] rsp_y_mm,
   output logic signed [38:0] rsp_z_mm,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [38:0]        csr_data
);
   localparam int N  = g2c_pkg::CORDIC_STAGES;
   localparam int L  = g2c_pkg::MUL_LAT;
   localparam int NS = g2c_pkg::NEWTON_STEPS;

   logic        enable, accept;
   logic [33:0] semi_ff;
   logic [38:0] flat_ff;
   logic        vld_ff [g2c_pkg::T_OUT-1];
   logic        rsp_valid_ff;

   g2c_pkg::cordic_type lat_c [N+1];
   g2c_pkg::cordic_type lon_c [N+1];
   g2c_pkg::cordic_type lat_in, lon_in;
   g2c_pkg::trig_type   sc_ff;
   g2c_pkg::trig_type   sc_dly_ff [g2c_pkg::SC_DEPTH];
   logic signed [63:0]  h_dly_ff [g2c_pkg::H_DEPTH];

   logic signed [63:0] fq, e2, gg, sq, e2sq, w_ff, n, nz, nh_ff, znh_ff, t;
   logic signed [63:0] xp, yp, zp;
   logic signed [63:0] nw_w [NS+1];
   logic signed [63:0] nw_y [NS+1];
   logic signed [38:0] x_ff, y_ff, z_ff;

   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && enable;
   assign req_stall = !enable || reset;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         semi_ff <= g2c_pkg::SEMI_RESET;
         flat_ff <= g2c_pkg::FLAT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            g2c_pkg::REG_SEMI_MAJOR: semi_ff <= csr_data[33:0];
            g2c_pkg::REG_FLATTENING: flat_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // fold the angle into [-pi/2, pi/2], negating sin and cos afterwards
   function automatic g2c_pkg::cordic_type reduce(input logic signed [63:0] z);
      g2c_pkg::cordic_type r;
      r.x = g2c_pkg::GAIN_INV_Q60;
      r.y = '0;
      r.z = z;
      r.neg = 1'b0;
      if (z > g2c_pkg::HALF_PI_Q60) begin
         r.z = z - g2c_pkg::PI_Q60;
         r.neg = 1'b1;
      end else if (z < -g2c_pkg::HALF_PI_Q60) begin
         r.z = z + g2c_pkg::PI_Q60;
         r.neg = 1'b1;
      end
      return r;
   endfunction

   assign lat_in = reduce(64'(req_lat_angle) <<< 31);
   assign lon_in = reduce(64'(req_lon_angle) <<< 31);

   always_ff @(posedge clock) begin
      if (enable) begin
         lat_c[0]    <= lat_in;
         lon_c[0]    <= lon_in;
         h_dly_ff[0] <= 64'(req_height_mm);
         for (int k = 1; k < g2c_pkg::H_DEPTH; k++) h_dly_ff[k] <= h_dly_ff[k-1];
         sc_ff.slat <= lat_c[N].neg ? -lat_c[N].y : lat_c[N].y;
         sc_ff.clat <= lat_c[N].neg ? -lat_c[N].x : lat_c[N].x;
         sc_ff.slon <= lon_c[N].neg ? -lon_c[N].y : lon_c[N].y;
         sc_ff.clon <= lon_c[N].neg ? -lon_c[N].x : lon_c[N].x;
         sc_dly_ff[0] <= sc_ff;
         for (int k = 1; k < g2c_pkg::SC_DEPTH; k++) sc_dly_ff[k] <= sc_dly_ff[k-1];
         w_ff   <= g2c_pkg::Q60_ONE - e2sq;
         nh_ff  <= n + h_dly_ff[g2c_pkg::T_N-1];
         znh_ff <= nz + h_dly_ff[g2c_pkg::T_N+L-1];
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cordic
         g2c_cordic_cell u_lat (.clock(clock), .enable(enable),
                                .stage_idx(g2c_pkg::STAGE_W'(gi)),
                                .d_in(lat_c[gi]), .d_out(lat_c[gi+1]));
         g2c_cordic_cell u_lon (.clock(clock), .enable(enable),
                                .stage_idx(g2c_pkg::STAGE_W'(gi)),
                                .d_in(lon_c[gi]), .d_out(lon_c[gi+1]));
      end
      for (gi = 0; gi < NS; gi++) begin : g_newton
         g2c_newton_cell u_nw (.clock(clock), .enable(enable),
                               .w_in(nw_w[gi]), .y_in(nw_y[gi]),
                               .w_out(nw_w[gi+1]), .y_out(nw_y[gi+1]));
      end
   endgenerate

   assign nw_w[0] = w_ff;
   assign nw_y[0] = g2c_pkg::NEWTON_Y0;

   // ellipsoid terms follow the registers and run free of the stall
   assign fq = $signed({5'd0, flat_ff, 20'd0});
   g2c_mul u_e2 (.clock(clock), .enable(1'b1), .a(fq), .b(g2c_pkg::Q60_TWO - fq),
                 .shift_amt(7'd60), .p(e2));
   g2c_mul u_gg (.clock(clock), .enable(1'b1), .a(g2c_pkg::Q60_ONE - fq),
                 .b(g2c_pkg::Q60_ONE - fq), .shift_amt(7'd60), .p(gg));

   g2c_mul u_sq (.clock(clock), .enable(enable), .a(sc_ff.slat), .b(sc_ff.slat),
                 .shift_amt(7'd60), .p(sq));
   g2c_mul u_e2sq (.clock(clock), .enable(enable), .a(e2), .b(sq),
                   .shift_amt(7'd60), .p(e2sq));
   g2c_mul u_n (.clock(clock), .enable(enable), .a($signed({30'd0, semi_ff})),
                .b(nw_y[NS]), .shift_amt(7'd60), .p(n));
   g2c_mul u_nz (.clock(clock), .enable(enable), .a(n), .b(gg),
                 .shift_amt(7'd60), .p(nz));
   g2c_mul u_t (.clock(clock), .enable(enable), .a(nh_ff),
                .b(sc_dly_ff[g2c_pkg::T_N-g2c_pkg::T_SC].clat),
                .shift_amt(7'd40), .p(t));
   g2c_mul u_x (.clock(clock), .enable(enable), .a(t),
                .b(sc_dly_ff[g2c_pkg::T_N+L-g2c_pkg::T_SC].clon),
                .shift_amt(7'd80), .p(xp));
   g2c_mul u_y (.clock(clock), .enable(enable), .a(t),
                .b(sc_dly_ff[g2c_pkg::T_N+L-g2c_pkg::T_SC].slon),
                .shift_amt(7'd80), .p(yp));
   g2c_mul u_z (.clock(clock), .enable(enable), .a(znh_ff),
                .b(sc_dly_ff[g2c_pkg::T_N+L-g2c_pkg::T_SC].slat),
                .shift_amt(7'd60), .p(zp));

   function automatic logic signed [38:0] sat(input logic signed [63:0] v);
      if (v > 64'(g2c_pkg::OUT_LIMIT)) return g2c_pkg::OUT_LIMIT;
      if (v < -64'(g2c_pkg::OUT_LIMIT)) return -g2c_pkg::OUT_LIMIT;
      return v[38:0];
   endfunction

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= sat(xp);
         y_ff <= sat(yp);
         z_ff <= sat(zp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < g2c_pkg::T_OUT-1; k++) vld_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= accept;
         for (int k = 1; k < g2c_pkg::T_OUT-1; k++) vld_ff[k] <= vld_ff[k-1];
         rsp_valid_ff <= vld_ff[g2c_pkg::T_OUT-2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_mm  = x_ff;
   assign rsp_y_mm  = y_ff;
   assign rsp_z_mm  = z_ff;

   `G2C_ASSERT_ANY(a_reset_clears, clock, reset |=> !rsp_valid_ff)
   `G2C_ASSERT(a_stall_holds_line, clock, reset, !enable |=> $stable(vld_ff[0]) && $stable(rsp_valid_ff))
   `G2C_ASSERT(a_stall_backpressure, clock, reset, req_stall == (rsp_valid_ff && rsp_stall))
   `G2C_ASSERT(a_x_sat, clock, reset, rsp_valid_ff |-> x_ff <= g2c_pkg::OUT_LIMIT && x_ff >= -g2c_pkg::OUT_LIMIT)
   `G2C_ASSERT(a_z_sat, clock, reset, rsp_valid_ff |-> z_ff <= g2c_pkg::OUT_LIMIT && z_ff >= -g2c_pkg::OUT_LIMIT)
endmodule

[tb/geodetic_to_cartesian_checker.sv]
// result checker for the geodetic to cartesian block: predicts x, y, z for every
// accepted request word and compares each response word in order
// depends on g2c_pkg for the csr register enum
`timescale 1ns / 1ps
module geodetic_to_cartesian_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [30:0] req_lat_angle,
   input  logic signed [31:0] req_lon_angle,
   input  logic signed [37:0] req_height_mm,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [38:0] rsp_x_mm,
   input  logic signed [38:0] rsp_y_mm,
   input  logic signed [38:0] rsp_z_mm,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [38:0]        csr_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 point_count
);
   localparam int NSTG = 32;
   localparam longint LIMIT_MM = 64'sd200000000000;
   localparam longint ONE_Q60 = 64'sd1 <<< 60;

   typedef struct packed {
      logic signed [38:0] x;
      logic signed [38:0] y;
      logic signed [38:0] z;
   } point_type;

   point_type coord_queue[$];
   logic [33:0] axis_mm;
   logic [38:0] flat_q40;
   longint arctan[NSTG];
   longint pi_val;
   longint gain_inv;

   function automatic longint mulsh(longint a, longint b, int s);
      logic [127:0] p;
      logic [63:0] ma, mb, q;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = {64'd0, ma} * {64'd0, mb};
      p = p >> s;
      q = p[63:0];
      return ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [63:0] arctan_inv(logic [63:0] m);
      logic [63:0] pw, acc, k;
      pw = (64'd1 << 62) / m;
      acc = 0;
      k = 0;
      while (pw != 0) begin
         if (k[0]) acc = acc - pw / (2 * k + 1);
         else acc = acc + pw / (2 * k + 1);
         pw = pw / m / m;
         k++;
      end
      return acc;
   endfunction

   function automatic longint rsqrt(longint w);
      longint y;
      y = 64'sd3 <<< 59;
      for (int n = 0; n < 8; n++)
         y = mulsh(y, 3 * ONE_Q60 - mulsh(w, mulsh(y, y, 60), 60), 61);
      return y;
   endfunction

   task automatic rotate(input longint ang, output longint s, output longint c);
      longint x, y, dx, dy;
      bit flip;
      x = gain_inv;
      y = 0;
      flip = 0;
      if (ang > (pi_val >>> 1)) begin
         ang -= pi_val;
         flip = 1;
      end else if (ang < -(pi_val >>> 1)) begin
         ang += pi_val;
         flip = 1;
      end
      for (int i = 0; i < NSTG; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (ang >= 0) begin
            x -= dx; y += dy; ang -= arctan[i];
         end else begin
            x += dx; y -= dy; ang += arctan[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic signed [38:0] clip(longint v);
      if (v > LIMIT_MM) v = LIMIT_MM;
      if (v < -LIMIT_MM) v = -LIMIT_MM;
      return v[38:0];
   endfunction

   task automatic predict_point(input longint lat, input longint lon, input longint h);
      longint slat, clat, slon, clon, fq, e2, w, nr, g, nz, t;
      point_type p;
      rotate(lat <<< 31, slat, clat);
      rotate(lon <<< 31, slon, clon);
      fq = longint'(flat_q40) <<< 20;
      e2 = mulsh(fq, 2 * ONE_Q60 - fq, 60);
      w = ONE_Q60 - mulsh(e2, mulsh(slat, slat, 60), 60);
      nr = mulsh(longint'(axis_mm), rsqrt(w), 60);
      g = ONE_Q60 - fq;
      nz = mulsh(nr, mulsh(g, g, 60), 60);
      t = mulsh(nr + h, clat, 40);
      p.x = clip(mulsh(t, clon, 80));
      p.y = clip(mulsh(t, slon, 80));
      p.z = clip(mulsh(nz + h, slat, 60));
      coord_queue.push_back(p);
   endtask

   initial begin
      longint prod;
      pi_val = 4 * arctan_inv(5) - arctan_inv(239);
      arctan[0] = pi_val >>> 2;
      for (int i = 1; i < NSTG; i++) arctan[i] = arctan_inv(64'd1 << i) >> 2;
      prod = ONE_Q60;
      for (int i = 0; i < NSTG; i++) if (2 * i < 62) prod += prod >>> (2 * i);
      gain_inv = rsqrt(prod >>> 2) >>> 1;
      fail_count = 0;
      point_count = 0;
   end

   assign pending_count = coord_queue.size();

   always @(posedge clock) begin
      point_type e;
      if (reset) begin
         axis_mm <= 34'd6378137000;
         flat_q40 <= 39'd3686454311;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == g2c_pkg::REG_SEMI_MAJOR) axis_mm <= csr_data[33:0];
            else flat_q40 <= csr_data;
         end
         if (req_valid && !req_stall)
            predict_point(req_lat_angle, req_lon_angle, req_height_mm);
         if (rsp_valid && !rsp_stall) begin
            point_count++;
            if (coord_queue.size() == 0) begin
               $error("response word with no point pending");
               fail_count++;
            end else begin
               e = coord_queue.pop_front();
               if (rsp_x_mm !== e.x) begin
                  $error("x_mm expected %0d got %0d", e.x, rsp_x_mm);
                  fail_count++;
               end
               if (rsp_y_mm !== e.y) begin
                  $error("y_mm expected %0d got %0d", e.y, rsp_y_mm);
                  fail_count++;
               end
               if (rsp_z_mm !== e.z) begin
                  $error("z_mm expected %0d got %0d", e.z, rsp_z_mm);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

[tb/testbench.sv]
// stimulus and verdict for the geodetic to cartesian block
// depends on g2c_pkg, geodetic_to_cartesian and geodetic_to_cartesian_checker
`timescale 1ns / 1ps
module testbench;
   localparam int LATENCY = 161;
   localparam longint LAT_MAX = 843314857;
   localparam longint LON_MAX = 1686629713;
   localparam longint H_MAX = 64'sd100000000000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0;
   logic req_stall, rsp_valid, csr_ready;
   logic signed [30:0] req_lat_angle = 0;
   logic signed [31:0] req_lon_angle = 0;
   logic signed [37:0] req_height_mm = 0;
   logic signed [38:0] rsp_x_mm, rsp_y_mm, rsp_z_mm;
   logic [0:0] csr_index = 0;
   logic [38:0] csr_data = 0;
   int fail_count, pending_count, point_count;
   int sent_count = 0;
   bit hold_rsp = 0;
   bit stim_done = 0;
   longint cycle_count = 0;

   always #10 clock = ~clock;

   geodetic_to_cartesian i_dut (.*);
   geodetic_to_cartesian_checker i_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls per word, one long hold-off when asked
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if ($urandom_range(0, 2) == 0) n = 0;
         if (n != 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   task automatic send_point(longint lat, longint lon, longint h, bit gaps);
      int n;
      n = gaps ? $urandom_range(0, 17) : 0;
      if (gaps && $urandom_range(0, 2) == 0) n = 0;
      if (n != 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_lat_angle <= lat[30:0];
      req_lon_angle <= lon[31:0];
      req_height_mm <= h[37:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain_all();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_reg(g2c_pkg::csr_reg_type idx, logic [38:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic longint rnd_range(longint lim);
      longint v;
      v = {$urandom, $urandom};
      if (v < 0) v = -v;
      v = v % (2 * lim + 1);
      return v - lim;
   endfunction

   task automatic random_points(int count, bit gaps);
      longint lat, lon, h;
      for (int i = 0; i < count; i++) begin
         lat = rnd_range(LAT_MAX);
         lon = rnd_range(LON_MAX);
         case ($urandom_range(0, 4))
            0: h = rnd_range(H_MAX);
            1: h = rnd_range(10000000);
            // raw bit patterns, outside the stated ranges too
            2: begin
               lat = $signed(31'($urandom));
               lon = $signed(32'($urandom));
               h = $signed(38'({$urandom, $urandom}));
            end
            default: h = rnd_range(64'sd9000000000);
         endcase
         send_point(lat, lon, h, gaps);
      end
   endtask

   initial begin
      longint lats[5];
      longint lons[5];
      longint hs[5];
      lats = '{0, LAT_MAX, -LAT_MAX, 843314856, 1073741823};
      lons = '{0, LON_MAX, -LON_MAX, -1073741824, 2147483647};
      hs = '{0, H_MAX, -H_MAX, 64'sd137438953471, -64'sd137438953472};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, quarter-turn wrap, saturation
      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 4; j++)
            send_point(lats[i], lons[(i + j) % 5], hs[(i + 2 * j) % 5], 0);
      send_point(-1073741824, -64'sd2147483648, -1, 0);
      send_point(-1, -1, 1, 0);
      drain_all();

      random_points(120, 1);
      // sender keeps offering while the receiver holds off
      hold_rsp = 1;
      random_points(200, 0);
      drain_all();

      write_reg(g2c_pkg::REG_SEMI_MAJOR, 39'd10000000000);
      write_reg(g2c_pkg::REG_FLATTENING, 39'd549755813887);
      random_points(60, 1);
      drain_all();
      write_reg(g2c_pkg::REG_SEMI_MAJOR, 39'd1000000000);
      write_reg(g2c_pkg::REG_FLATTENING, 39'd0);
      random_points(60, 1);
      drain_all();
      write_reg(g2c_pkg::REG_SEMI_MAJOR, 39'd0);
      write_reg(g2c_pkg::REG_FLATTENING, 39'h7f_ffff_ffff);
      random_points(20, 1);
      drain_all();
      write_reg(g2c_pkg::REG_SEMI_MAJOR, 39'h7f_ffff_ffff);
      write_reg(g2c_pkg::REG_FLATTENING, {7'd0, $urandom});
      random_points(20, 1);
      drain_all();
      write_reg(g2c_pkg::REG_SEMI_MAJOR, 39'd6378137000);
      write_reg(g2c_pkg::REG_FLATTENING, 39'd3686454311);
      random_points(70, 1);
      drain_all();

      $display("covered %0d points through %0d responses, 5 ellipsoid settings,",
               sent_count, point_count);
      $display("angle wrap, output saturation and a long response hold-off");
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
